### hw/rtl/d2f_pkg.sv
`timescale 1ns / 1ps
package d2f_pkg;

	localparam int MAX_PRECISION = 9;
	localparam logic [62:0] LIMIT_BITS = 63'h41DF_FFFF_FFC0_0000;
	localparam int PROD_W = 84;
	localparam int MANT_W = 53;
	localparam int SCALE_W = 30;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_A = 8'h61;

	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_NAN,
		KIND_BIG
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                neg;
		logic [31:0]         whole;
		logic [SCALE_W-1:0]  frac;
		logic [3:0]          prec;
	} job_t;

	function automatic logic [SCALE_W-1:0] pow10(input logic [3:0] p);
		logic [SCALE_W-1:0] r;
		case (p)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/d2f_if.sv
`timescale 1ns / 1ps
interface d2f_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

interface d2f_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic       too_large;
	modport source (output valid, output out_char, output last, output too_large, input ready);
	modport sink (input valid, input out_char, input last, input too_large, output ready);
endinterface

### hw/rtl/d2f_front.sv
`timescale 1ns / 1ps
module d2f_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    precision,
	d2f_in_if.sink        in_ch,
	output logic          push,
	output d2f_pkg::job_t push_job,
	input  logic          full
);
	import d2f_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_DEC, F_MUL, F_SUM, F_LZ1, F_LZ2, F_RND, F_SPL, F_FIN
	} fstate_t;

	fstate_t state_q;
	logic [62:0] ab_q;
	logic sign_q;
	logic [3:0] p_q;
	kind_t kind_q;
	logic neg_q;
	logic [10:0] k_q;
	logic [31:0] whole_q;
	logic [MANT_W-1:0] fm_q;
	logic [56:0] pp_lo_q;
	logic [55:0] pp_hi_q;
	logic [PROD_W-1:0] prod_q;
	logic [11:0] gnz_q;
	logic [2:0] ghi_q [12];
	logic [4:0] d_q;
	logic [PROD_W-1:0] rnd_q;
	logic [SCALE_W-1:0] frac_q;
	logic gt_q, eq_q;

	// Decode of the held bit pattern.
	logic [10:0] exp_w;
	logic [51:0] man_w;
	logic [MANT_W-1:0] m_w;
	logic [10:0] k_w;
	logic [63:0] sh_w;
	always_comb begin
		exp_w = ab_q[62:52];
		man_w = ab_q[51:0];
		m_w = {exp_w != 11'd0, man_w};
		k_w = (exp_w == 11'd0) ? 11'd1074 : 11'd1075 - exp_w;
		sh_w = 64'(m_w) >> k_w[5:0];
	end

	logic [SCALE_W-1:0] scale_w;
	assign scale_w = pow10(p_q);

	// Leading-one search, group stage.
	logic [11:0] gnz_w;
	logic [2:0] ghi_w [12];
	always_comb begin
		for (int g = 0; g < 12; g++) begin
			gnz_w[g] = |prod_q[7*g +: 7];
			ghi_w[g] = 3'd0;
			for (int b = 0; b < 7; b++) begin
				if (prod_q[7*g + b]) ghi_w[g] = 3'(b);
			end
		end
	end

	logic [6:0] blen_w;
	always_comb begin
		blen_w = 7'd0;
		for (int g = 0; g < 12; g++) begin
			if (gnz_q[g]) blen_w = 7'(7*g) + 7'(ghi_q[g]) + 7'd1;
		end
	end

	// Round the product to double precision.
	logic [PROD_W-1:0] mask_w, low_w, half_w, rnd_w;
	logic up_w;
	always_comb begin
		mask_w = (PROD_W'(1) << d_q) - PROD_W'(1);
		low_w = prod_q & mask_w;
		half_w = (d_q == 5'd0) ? '0 : PROD_W'(1) << (d_q - 5'd1);
		up_w = (d_q != 5'd0) && ((low_w > half_w) || (low_w == half_w && prod_q[d_q]));
		rnd_w = (prod_q & ~mask_w) + (up_w ? PROD_W'(1) << d_q : '0);
	end

	// Split the scaled fraction into integer digits and remainder.
	logic [PROD_W-1:0] fr_w, rem_w, hk_w;
	logic tiny_w;
	always_comb begin
		tiny_w = k_q >= 11'(PROD_W);
		fr_w = rnd_q >> k_q[6:0];
		rem_w = rnd_q & ((PROD_W'(1) << k_q[6:0]) - PROD_W'(1));
		hk_w = PROD_W'(1) << (k_q[6:0] - 7'd1);
	end

	// Final rounding with carry into the whole part.
	logic inc_w, roll_w;
	logic [SCALE_W-1:0] f1_w;
	logic [31:0] w1_w;
	always_comb begin
		inc_w = gt_q || (eq_q && (frac_q == '0 || frac_q[0]));
		f1_w = frac_q + SCALE_W'(inc_w);
		w1_w = whole_q;
		roll_w = inc_w && (f1_w >= scale_w) && (gt_q || p_q != 4'd0);
		if (roll_w) begin
			f1_w = '0;
			w1_w = whole_q + 32'd1;
		end
		if (p_q == 4'd0 && !roll_w && eq_q && whole_q[0]) w1_w = whole_q + 32'd1;
	end

	assign in_ch.ready = (state_q == F_IDLE);
	assign push = (state_q == F_FIN) && !full;
	always_comb begin
		push_job.kind = kind_q;
		push_job.neg = neg_q;
		push_job.whole = w1_w;
		push_job.frac = f1_w;
		push_job.prec = p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						ab_q <= in_ch.value_bits[62:0];
						sign_q <= in_ch.value_bits[63];
						p_q <= (precision > 4'(MAX_PRECISION)) ? 4'(MAX_PRECISION) : precision;
						state_q <= F_DEC;
					end
				end
				F_DEC: begin
					neg_q <= sign_q && (ab_q != '0);
					k_q <= k_w;
					whole_q <= (k_w >= 11'd64) ? 32'd0 : sh_w[31:0];
					fm_q <= (k_w >= 11'd53) ? m_w
						: m_w & ((MANT_W'(1) << k_w[5:0]) - MANT_W'(1));
					// The fraction is zeroed for the text-only classes; the whole part is not.
					if (exp_w == 11'h7FF && man_w != '0) begin
						kind_q <= KIND_NAN;
						gt_q <= 1'b0;
						eq_q <= 1'b0;
						frac_q <= '0;
						state_q <= F_FIN;
					end else if (ab_q > LIMIT_BITS) begin
						kind_q <= KIND_BIG;
						gt_q <= 1'b0;
						eq_q <= 1'b0;
						frac_q <= '0;
						state_q <= F_FIN;
					end else begin
						kind_q <= KIND_NUM;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					pp_lo_q <= 57'(fm_q[26:0]) * 57'(scale_w);
					pp_hi_q <= 56'(fm_q[52:27]) * 56'(scale_w);
					state_q <= F_SUM;
				end
				F_SUM: begin
					prod_q <= PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << 27);
					state_q <= F_LZ1;
				end
				F_LZ1: begin
					gnz_q <= gnz_w;
					ghi_q <= ghi_w;
					state_q <= F_LZ2;
				end
				F_LZ2: begin
					d_q <= (blen_w > 7'(MANT_W)) ? 5'(blen_w - 7'(MANT_W)) : 5'd0;
					state_q <= F_RND;
				end
				F_RND: begin
					rnd_q <= rnd_w;
					state_q <= F_SPL;
				end
				F_SPL: begin
					if (tiny_w) begin
						frac_q <= '0;
						gt_q <= 1'b0;
						eq_q <= 1'b0;
					end else begin
						frac_q <= fr_w[SCALE_W-1:0];
						gt_q <= rem_w > hk_w;
						eq_q <= rem_w == hk_w;
					end
					state_q <= F_FIN;
				end
				F_FIN: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/d2f_queue.sv
`timescale 1ns / 1ps
module d2f_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  d2f_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output d2f_pkg::job_t pop_job,
	output logic          empty
);
	import d2f_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hw/rtl/d2f_back.sv
`timescale 1ns / 1ps
module d2f_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  d2f_pkg::job_t pop_job,
	output logic          pop,
	d2f_out_if.source     out_ch
);
	import d2f_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_WDIG, B_FDIG, B_EMIT} bstate_t;

	bstate_t state_q;
	job_t job_q;
	logic [31:0] dv_q;
	logic [3:0] wdig_q [10];
	logic [3:0] fdig_q [9];
	logic [3:0] nw_q;
	logic [3:0] fc_q;
	logic [4:0] e_q;
	logic ov_q;
	logic [7:0] oc_q;
	logic ol_q, ob_q;

	// Divide by ten through the reciprocal.
	logic [63:0] qp_w;
	logic [31:0] q_w;
	logic [3:0] r_w;
	always_comb begin
		qp_w = 64'(dv_q) * 64'(32'hCCCC_CCCD);
		q_w = 32'(qp_w >> 35);
		r_w = 4'(dv_q - ((q_w << 3) + (q_w << 1)));
	end

	logic [4:0] n_w, j_w;
	logic [3:0] wi_w, fi_w;
	logic [7:0] ch_w;
	always_comb begin
		n_w = 5'(job_q.neg) + 5'(nw_q) + ((job_q.prec != 4'd0) ? 5'(job_q.prec) + 5'd1 : 5'd0);
		j_w = e_q - 5'(job_q.neg);
		wi_w = 4'(5'(nw_q) - 5'd1 - j_w);
		fi_w = 4'(j_w - 5'(nw_q) - 5'd1);
		ch_w = CH_ZERO;
		case (job_q.kind)
			KIND_NAN: ch_w = (e_q == 5'd1) ? CH_A : CH_N;
			KIND_BIG: ch_w = 8'd0;
			default: begin
				if (job_q.neg && e_q == 5'd0) ch_w = CH_MINUS;
				else if (j_w < 5'(nw_q)) ch_w = CH_ZERO + 8'(wdig_q[wi_w]);
				else if (j_w == 5'(nw_q)) ch_w = CH_DOT;
				else ch_w = CH_ZERO + 8'(fdig_q[fi_w]);
			end
		endcase
	end

	logic [4:0] len_w;
	assign len_w = (job_q.kind == KIND_NAN) ? 5'd3 : (job_q.kind == KIND_BIG) ? 5'd1 : n_w;

	// The output register takes a new character when it is empty or being drained.
	logic ld_w;
	assign ld_w = (state_q == B_EMIT) && (!ov_q || out_ch.ready);

	assign pop = (state_q == B_IDLE) && !empty;
	assign out_ch.valid = ov_q;
	assign out_ch.out_char = oc_q;
	assign out_ch.last = ol_q;
	assign out_ch.too_large = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (ld_w) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						job_q <= pop_job;
						dv_q <= pop_job.whole;
						nw_q <= 4'd0;
						fc_q <= pop_job.prec;
						e_q <= 5'd0;
						state_q <= (pop_job.kind == KIND_NUM) ? B_WDIG : B_EMIT;
					end
				end
				B_WDIG: begin
					wdig_q[nw_q] <= r_w;
					nw_q <= nw_q + 4'd1;
					if (q_w == 32'd0 || nw_q == 4'd9) begin
						dv_q <= 32'(job_q.frac);
						state_q <= (job_q.prec == 4'd0) ? B_EMIT : B_FDIG;
					end else begin
						dv_q <= q_w;
					end
				end
				B_FDIG: begin
					fdig_q[fc_q - 4'd1] <= r_w;
					fc_q <= fc_q - 4'd1;
					dv_q <= q_w;
					if (fc_q == 4'd1) state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (ld_w) begin
						oc_q <= ch_w;
						ol_q <= (e_q == len_w - 5'd1);
						ob_q <= (job_q.kind == KIND_BIG);
						e_q <= e_q + 5'd1;
						if (e_q == len_w - 5'd1) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/double_to_fixed_decimal_text_unit.sv
`timescale 1ns / 1ps
// Fixed-point decimal text of an IEEE double.
// in_ch carries one 64-bit double bit pattern per transaction; out_ch returns
// its text one ASCII character per transaction, most significant first, with
// last set on the final character. NaN gives "nan", negative values get a
// leading minus sign, and magnitudes above 2147483647 (infinity included)
// give a single transaction with too_large set and out_char zero.
// cfg_we/cfg_wdata write the precision register (0 to 9 fraction digits,
// larger codes act as 9); write it only while the unit is idle.
// The front end works each number through decode, a split 53x30 multiply,
// a two-step leading-one search, rounding, the split into digits and the
// final carry, and takes no new number until it is through with the last.
// The back end takes one cycle per whole digit and per fraction digit through
// a shared divide-by-ten, then one cycle per character while the receiver
// accepts. A two-entry queue lets the front end take the next number while
// the back end is still emitting.
// Reset clears all control state and sets precision to 0. When the receiver
// stalls, the held character stays put and the queue then fills and stops
// input acceptance.
module double_to_fixed_decimal_text_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	d2f_in_if.sink     in_ch,
	d2f_out_if.source  out_ch
);
	import d2f_pkg::*;

	logic [3:0] precision_q;
	logic push, pop, full, empty;
	job_t push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= 4'd0;
		end else if (cfg_we) begin
			precision_q <= cfg_wdata;
		end
	end

	// Front end: classification and the floating-point rounding stages.
	d2f_front u_front (
		.clk(clk), .arst_n(arst_n), .precision(precision_q),
		.in_ch(in_ch), .push(push), .push_job(push_job), .full(full)
	);

	// Queue of finished jobs between the two halves.
	d2f_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop(pop), .pop_job(pop_job), .empty(empty)
	);

	// Back end: digit extraction and character output.
	d2f_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .pop_job(pop_job), .pop(pop),
		.out_ch(out_ch)
	);

endmodule

### hw/rtl/d2f_checker.sv
`timescale 1ns / 1ps
module d2f_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last,
	input logic       out_big
);
	a_big_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_big |-> out_last) else $error("too_large without last");
	a_big_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_big |-> out_char == 8'd0) else $error("too_large with text");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char))
		else $error("stalled character changed");
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid) else $error("output valid in reset");
endmodule

bind double_to_fixed_decimal_text_unit d2f_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_char(out_ch.out_char), .out_last(out_ch.last), .out_big(out_ch.too_large)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the fixed-point decimal text unit. A table of directed
// numbers is sent first, then random numbers under several precision
// settings, while both channels idle in random bursts.
module tb_top;
	import d2f_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       big;
	} text_char_t;

	// Marker in the directed table for a number that is too large to print.
	localparam string TOO_BIG = "BIG";
	localparam int DIR_N = 19;
	localparam int PHASE_N = 8;
	localparam int PHASE_ITEMS = 26;
	// A long hold on the receiver, long enough to fill the internal queue.
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	d2f_in_if  in_if();
	d2f_out_if out_if();

	double_to_fixed_decimal_text_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// Characters still awaited from the unit, oldest at the front.
	text_char_t pending_chars[$];
	logic [3:0] prec_reg;
	int errors;
	bit quiet;
	bit hold_req;

	// Directed numbers. Where the text is typed in it can be read straight
	// off the value; an empty text means the predictor works it out.
	logic [63:0] dir_bits [DIR_N] = '{
		64'h0000_0000_0000_0000,  // zero
		64'h8000_0000_0000_0000,  // negative zero prints without a sign
		64'h3FF0_0000_0000_0000,  // one
		64'hBFF0_0000_0000_0000,  // minus one
		64'h3FE0_0000_0000_0000,  // exact half
		64'h4004_0000_0000_0000,  // 2.5, a tie on an even whole part
		64'h400C_0000_0000_0000,  // 3.5, a tie on an odd whole part
		64'h7FF8_0000_0000_0000,  // quiet NaN
		64'h7FF0_0000_0000_0001,  // signalling NaN
		64'hFFFF_FFFF_FFFF_FFFF,  // negative NaN, all ones
		64'h7FF0_0000_0000_0000,  // plus infinity
		64'hFFF0_0000_0000_0000,  // minus infinity
		64'h41DF_FFFF_FFC0_0000,  // the largest whole part accepted
		64'hC1DF_FFFF_FFC0_0000,  // its negative
		64'h41DF_FFFF_FFE0_0000,  // just above the limit
		64'h0000_0000_0000_0001,  // smallest denormal
		64'h3FEF_FFFF_FFFF_FFFF,  // just below one
		64'h4009_21FB_5444_2D18,  // pi
		64'h7FEF_FFFF_FFFF_FFFF   // largest finite double
	};
	string dir_text [DIR_N] = '{
		"0", "0", "1", "-1", "", "", "", "nan", "nan", "nan", TOO_BIG, TOO_BIG,
		"2147483647", "-2147483647", TOO_BIG, "0", "", "", TOO_BIG
	};
	logic [3:0] phase_prec [PHASE_N] = '{4'd9, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd2, 4'd9};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_err(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic push_text(input string s);
		text_char_t c;
		if (s == TOO_BIG) begin
			c.ch = 8'd0;
			c.last = 1'b1;
			c.big = 1'b1;
			pending_chars.push_back(c);
		end else begin
			for (int i = 0; i < s.len(); i++) begin
				c.ch = s[i];
				c.last = (i == s.len() - 1);
				c.big = 1'b0;
				pending_chars.push_back(c);
			end
		end
	endtask

	// Works out the text of one number under the current precision, with the
	// same two rounding stages as the unit, and queues its characters.
	task automatic predict_text(input logic [63:0] bits);
		real mag, tmp, diff, scale;
		longint unsigned whole;
		longint unsigned frac;
		int p;
		bit neg;
		string s, fd;
		if (bits[62:52] == 11'h7FF && bits[51:0] != 0) begin
			push_text("nan");
			return;
		end
		mag = $bitstoreal(bits);
		neg = (mag < 0.0);
		if (neg)
			mag = -mag;
		if (mag > 2147483647.0) begin
			push_text(TOO_BIG);
			return;
		end
		p = (prec_reg > MAX_PRECISION) ? MAX_PRECISION : prec_reg;
		scale = 1.0;
		for (int i = 0; i < p; i++)
			scale = scale * 10.0;
		whole = $rtoi(mag);
		tmp = (mag - whole) * scale;
		frac = $rtoi(tmp);
		diff = tmp - frac;
		if (diff > 0.5) begin
			frac++;
			// This carry applies at zero precision too, ahead of the second stage.
			if (frac >= scale) begin
				frac = 0;
				whole++;
			end
		end else if (diff == 0.5 && (frac == 0 || frac[0])) begin
			frac++;
			if (p > 0 && frac >= scale) begin
				frac = 0;
				whole++;
			end
		end
		if (p == 0) begin
			diff = mag - whole;
			if (diff > 0.5)
				whole++;
			else if (diff == 0.5 && whole[0])
				whole++;
		end
		s = neg ? "-" : "";
		s = {s, $sformatf("%0d", whole)};
		if (p > 0) begin
			// Exactly p digits: a fraction that rounded up to the scale keeps
			// only its low digits.
			fd = "";
			for (int i = 0; i < p; i++) begin
				fd = {$sformatf("%0d", frac % 10), fd};
				frac = frac / 10;
			end
			s = {s, ".", fd};
		end
		push_text(s);
	endtask

	// Random numbers of several flavours: raw patterns, small values with a
	// random fraction, exact ties, values near the limit and special values.
	function automatic logic [63:0] random_number();
		real r;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: return {$urandom, $urandom};
			2, 3, 4: r = $urandom_range(0, 999) + $urandom / 4294967296.0;
			5, 6: r = $urandom_range(0, 99) + $urandom_range(0, 255) / 256.0;
			7: r = $urandom_range(0, 3) * 1000000.0 + $urandom_range(0, 7) / 8.0;
			8: r = 2147483647.0 - $urandom_range(0, 2000) - $urandom_range(0, 15) / 16.0;
			default: return dir_bits[$urandom_range(0, DIR_N - 1)];
		endcase
		if ($urandom_range(0, 1))
			r = -r;
		return $realtobits(r);
	endfunction

	// Offers one number and waits until it is accepted. The predictor runs
	// at the acceptance edge, so it always sees the precision in force.
	task automatic send_number(input logic [63:0] bits, input string typed);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.value_bits <= bits;
		do
			@(posedge clk);
		while (!in_if.ready);
		if (typed == "")
			predict_text(bits);
		else
			push_text(typed);
		@(negedge clk);
	endtask

	// Lets the unit drain before touching the precision register.
	task automatic write_precision(input logic [3:0] p);
		in_if.valid <= 1'b0;
		wait (pending_chars.size() == 0);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		prec_reg = p;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stall bursts, one long hold, none at the end.
	initial begin
		int stall_left;
		stall_left = 0;
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Checker: every character transaction is compared with the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_chars.size() == 0) begin
				report_err($sformatf("unexpected character 0x%02h", out_if.out_char));
			end else begin
				want = pending_chars.pop_front();
				if (out_if.out_char !== want.ch || out_if.last !== want.last ||
						out_if.too_large !== want.big)
					report_err($sformatf("got char 0x%02h last %b big %b, wanted 0x%02h %b %b",
						out_if.out_char, out_if.last, out_if.too_large,
						want.ch, want.last, want.big));
			end
		end
	end

	initial begin
		errors = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		prec_reg = 4'd0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		in_if.valid = 1'b0;
		in_if.value_bits = 64'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset precision of zero.
		for (int i = 0; i < DIR_N; i++)
			send_number(dir_bits[i], dir_text[i]);

		for (int ph = 0; ph < PHASE_N; ph++) begin
			write_precision(phase_prec[ph]);
			// In the second phase the receiver holds off while numbers keep
			// arriving, so the queue fills and the input stalls.
			if (ph == 1)
				hold_req = 1'b1;
			if (ph == PHASE_N - 1)
				quiet = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_number(random_number(), "");
		end
		in_if.valid <= 1'b0;

		wait (pending_chars.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
